FILE: sv/sorted_topk_insert_macros.svh
// assertion helpers shared by the ranking block
`ifndef SORTED_TOPK_INSERT_MACROS_SVH
`define SORTED_TOPK_INSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define STKI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define STKI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/stki_pkg.sv
package stki_pkg;

  localparam int DEPTH   = 1024;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int SCORE_W = 21;
  localparam int TIME_W  = 32;
  localparam int TAG_W   = 16;
  localparam int CAP_W   = 11;
  localparam int POS_W   = 10;
  localparam int RIDX_W  = 10;
  localparam int TOTAL_W = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1000;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  // select tree: 4-way registered levels
  localparam int TREE_LVLS   = (IDX_W + 1) / 2;
  localparam int TREE_LEAVES = 1 << (2 * TREE_LVLS);

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  stamp;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    entry_t           ent;
  } leaf_t;

  // item broadcast to every cell
  typedef struct packed {
    logic               read;
    logic [SCORE_W-1:0] score;
    logic [TIME_W-1:0]  stamp;
    logic [RIDX_W-1:0]  ridx;
  } probe_t;

  // first node of tree level l (level 1 sits right above the leaves)
  function automatic int lvl_off(input int l);
    int sum;
    sum = 0;
    for (int i = 1; i < l; i++) begin
      sum = sum + (TREE_LEAVES >> (2 * i));
    end
    return sum;
  endfunction

  localparam int TREE_NODES = lvl_off(TREE_LVLS + 1);

endpackage

FILE: sv/sorted_topk_insert.sv
// the done strobe rises after start is taken, once the seek and commit states have run
// a new item is taken only while idle; busy stays high from a taken start through commit
// the seek wait is set by the registered 4-way select tree over the rank cells
// an accepted insert moves the cells from its rank on down one place; the receiver cannot stall
// reset: entry count and batch halt clear, capacity returns to 1000; entries are undefined
`include "sorted_topk_insert_macros.svh"

module sorted_topk_insert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [stki_pkg::SCORE_W-1:0]  score,
  input  logic [stki_pkg::TIME_W-1:0]   timestamp,
  input  logic [stki_pkg::TAG_W-1:0]    tag,
  input  logic                          batch_start,
  input  logic [stki_pkg::RIDX_W-1:0]   read_index,
  input  logic                          cfg_wr_en,
  input  logic [stki_pkg::CAP_W-1:0]    cfg_wr_data,
  output logic                          done,
  output logic                          accepted,
  output logic [stki_pkg::POS_W-1:0]    position,
  output logic [stki_pkg::TOTAL_W-1:0]  entry_total,
  output logic                          read_valid,
  output logic [stki_pkg::SCORE_W-1:0]  read_score,
  output logic [stki_pkg::TIME_W-1:0]   read_timestamp,
  output logic [stki_pkg::TAG_W-1:0]    read_tag
);
  import stki_pkg::*;

  localparam int SEEK_W = $clog2(TREE_LVLS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SEEK, ST_COMMIT} state_t;

  state_t             state;
  logic [SEEK_W-1:0]  seek_cnt;
  logic [CNT_W-1:0]   count;
  logic               halted;
  logic [CAP_W-1:0]   cap_limit;
  probe_t             probe;
  logic [TAG_W-1:0]   itm_tag;
  logic               itm_bstart;

  entry_t new_ent;
  entry_t ents   [DEPTH];
  logic   aheads [DEPTH];
  leaf_t  leaves [DEPTH];
  leaf_t  root;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] rank;
  logic [CNT_W:0]   count_inc;
  logic [CNT_W-1:0] grown;
  logic             held;
  logic             is_insert;
  logic             ins_ok;
  logic             rd_ok;
  logic             halted_next;
  logic [CNT_W-1:0] count_next;
  logic             commit;

  assign busy    = (state != ST_IDLE);
  assign new_ent = '{score: probe.score, stamp: probe.stamp, tag: itm_tag};

  for (genvar k = 0; k < DEPTH; k++) begin : g_chain
    if (k == 0) begin : g_head
      stki_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_W'(k)),
        .count      (count),
        .probe      (probe),
        .commit     (commit),
        .new_ent    (new_ent),
        .left_ent   (new_ent),
        .left_ahead (1'b1),
        .ent        (ents[k]),
        .ahead      (aheads[k]),
        .leaf       (leaves[k])
      );
    end else begin : g_body
      stki_cell u_cell (
        .clk        (clk),
        .cell_idx   (IDX_W'(k)),
        .count      (count),
        .probe      (probe),
        .commit     (commit),
        .new_ent    (new_ent),
        .left_ent   (ents[k-1]),
        .left_ahead (aheads[k-1]),
        .ent        (ents[k]),
        .ahead      (aheads[k]),
        .leaf       (leaves[k])
      );
    end
  end

  stki_tree u_tree (
    .clk    (clk),
    .leaves (leaves),
    .root   (root)
  );

  always_comb begin
    if (cap_limit == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_limit) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_limit);
    end
    // no boundary cell means every held entry is ahead
    rank        = root.hit ? CNT_W'(root.idx) : count;
    count_inc   = {1'b0, count} + 1'b1;
    grown       = (count_inc > {1'b0, eff_cap}) ? eff_cap : count_inc[CNT_W-1:0];
    held        = halted && !itm_bstart;
    is_insert   = (probe.read == MODE_INSERT);
    ins_ok      = is_insert && !held && (probe.score != '0) && (rank < eff_cap);
    rd_ok       = !is_insert && root.hit && (32'(probe.ridx) < 32'(count));
    halted_next = is_insert ? (held || (probe.score == '0)) : halted;
    count_next  = ins_ok ? grown : count;
    commit      = (state == ST_COMMIT) && ins_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seek_cnt  <= '0;
      done      <= 1'b0;
      count     <= '0;
      halted    <= 1'b0;
      cap_limit <= CAP_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            probe      <= '{read: mode, score: score, stamp: timestamp, ridx: read_index};
            itm_tag    <= tag;
            itm_bstart <= batch_start;
            seek_cnt   <= '0;
            state      <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          // wait for the select tree to settle on this beat
          seek_cnt <= seek_cnt + 1'b1;
          if (seek_cnt == SEEK_W'(TREE_LVLS - 1)) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          count          <= count_next;
          halted         <= halted_next;
          done           <= 1'b1;
          accepted       <= ins_ok;
          position       <= ins_ok ? POS_W'(rank) : '0;
          entry_total    <= TOTAL_W'(count_next);
          read_valid     <= rd_ok;
          read_score     <= rd_ok ? root.ent.score : '0;
          read_timestamp <= rd_ok ? root.ent.stamp : '0;
          read_tag       <= rd_ok ? root.ent.tag : '0;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `STKI_ASSERT_NXT(a_start_busy, start && !busy, busy, "taken beat did not raise busy")
  `STKI_ASSERT_NOW(a_done_after_busy, done, $past(busy), "result without a beat in flight")
  `STKI_ASSERT_NOW(a_one_kind, done, !(accepted && read_valid), "insert and read both flagged")
  `STKI_ASSERT_NOW(a_pos_in_list, done && accepted, 32'(position) < 32'(entry_total),
                   "insert position beyond entry total")
  `STKI_ASSERT_NOW(a_count_bound, 1'b1, 32'(count) <= 32'(DEPTH), "entry count beyond depth")

endmodule

FILE: sv/stki_cell.sv
module stki_cell (
  input  logic                      clk,
  input  logic [stki_pkg::IDX_W-1:0] cell_idx,
  input  logic [stki_pkg::CNT_W-1:0] count,
  input  stki_pkg::probe_t          probe,
  input  logic                      commit,
  input  stki_pkg::entry_t          new_ent,
  input  stki_pkg::entry_t          left_ent,
  input  logic                      left_ahead,
  output stki_pkg::entry_t          ent,
  output logic                      ahead,
  output stki_pkg::leaf_t           leaf
);
  import stki_pkg::*;

  logic occupied;
  logic greater;
  logic boundary;
  logic sel;

  always_comb begin
    occupied = CNT_W'(cell_idx) < count;
    greater  = (ent.score > probe.score) ||
               ((ent.score == probe.score) && (ent.stamp > probe.stamp));
    ahead    = occupied && greater;
    // first cell not ahead of the new record is where it lands
    boundary = left_ahead && !ahead;
    sel      = (probe.read == MODE_READ) ? (32'(cell_idx) == 32'(probe.ridx)) : boundary;
    leaf.hit = sel;
    leaf.idx = sel ? cell_idx : '0;
    leaf.ent = sel ? ent : '0;
  end

  always_ff @(posedge clk) begin
    if (commit && !ahead) begin
      ent <= left_ahead ? new_ent : left_ent;
    end
  end

endmodule

FILE: sv/stki_tree.sv
module stki_tree (
  input  logic            clk,
  input  stki_pkg::leaf_t leaves [stki_pkg::DEPTH],
  output stki_pkg::leaf_t root
);
  import stki_pkg::*;

  leaf_t pad  [TREE_LEAVES];
  leaf_t node [TREE_NODES];

  for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_pad
    if (i < DEPTH) begin : g_used
      assign pad[i] = leaves[i];
    end else begin : g_empty
      assign pad[i] = '0;
    end
  end

  // at most one leaf is selected, so an or-reduce picks it out
  for (genvar l = 1; l <= TREE_LVLS; l++) begin : g_lvl
    localparam int N   = TREE_LEAVES >> (2 * l);
    localparam int OFF = lvl_off(l);
    localparam int SRC = lvl_off(l - 1);
    for (genvar n = 0; n < N; n++) begin : g_node
      if (l == 1) begin : g_first
        always_ff @(posedge clk) begin
          node[OFF+n] <= pad[4*n] | pad[4*n+1] | pad[4*n+2] | pad[4*n+3];
        end
      end else begin : g_upper
        always_ff @(posedge clk) begin
          node[OFF+n] <= node[SRC+4*n] | node[SRC+4*n+1] |
                         node[SRC+4*n+2] | node[SRC+4*n+3];
        end
      end
    end
  end

  assign root = node[TREE_NODES-1];

endmodule
